FILE: rtl/core/gse_pkg.sv
// Shared types, constants and move tables of the grid successor expander.
// No dependencies; the move unit, the top level and the testbench take names from here.
package gse_pkg;

	// Grid geometry.
	localparam int MaxRows = 64;
	localparam int MaxCols = 64;
	localparam int RowW    = $clog2(MaxRows);
	localparam int ColW    = $clog2(MaxCols);
	localparam int DimW    = 7;

	// Request modes.
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_FILL  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// Configuration register indexes.
	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_FREAD  = 6'b000010,
		ST_FWRITE = 6'b000100,
		ST_QREAD  = 6'b001000,
		ST_EVAL   = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	// Input request payload.
	typedef struct packed {
		logic [1:0]      mode;
		logic [RowW-1:0] row;
		logic [ColW-1:0] col;
		logic            cell_value;
		logic [DimW-1:0] row_end;
		logic [DimW-1:0] col_end;
	} req_t;

	// Result payload.
	typedef struct packed {
		logic [RowW-1:0] next_row;
		logic [ColW-1:0] next_col;
		logic [2:0]      move_index;
		logic            found;
		logic            last;
	} rsp_t;

	// Verdict of the move unit for one move.
	typedef struct packed {
		logic            valid;
		logic [RowW-1:0] row;
		logic [ColW-1:0] col;
	} move_res_t;

	// Row offset of each move, in the fixed order.
	function automatic logic signed [1:0] move_dr(input logic [2:0] k);
		logic signed [1:0] d;
		case (k)
			3'd0:    d = 2'sd0;
			3'd1:    d = 2'sd1;
			3'd2:    d = 2'sd1;
			3'd3:    d = 2'sd1;
			3'd4:    d = 2'sd0;
			default: d = -2'sd1;
		endcase
		return d;
	endfunction

	// Column offset of each move, in the fixed order.
	function automatic logic signed [1:0] move_dc(input logic [2:0] k);
		logic signed [1:0] d;
		case (k)
			3'd0:    d = 2'sd1;
			3'd1:    d = 2'sd1;
			3'd2:    d = 2'sd0;
			3'd6:    d = 2'sd0;
			3'd7:    d = 2'sd1;
			default: d = -2'sd1;
		endcase
		return d;
	endfunction

endpackage

FILE: rtl/core/gse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gse_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/gse_move_unit.sv
// Shared move unit: applies one move to the query cell and checks bounds and obstacles.
// Depends on gse_pkg for geometry, move tables and the result struct.
module gse_move_unit (
	input  logic [2:0]                   move_k,
	input  logic [gse_pkg::RowW-1:0]     row,
	input  logic [gse_pkg::ColW-1:0]     col,
	input  logic [gse_pkg::DimW-1:0]     rows_used,
	input  logic [gse_pkg::DimW-1:0]     cols_used,
	input  logic [gse_pkg::MaxCols-1:0]  row_up,
	input  logic [gse_pkg::MaxCols-1:0]  row_mid,
	input  logic [gse_pkg::MaxCols-1:0]  row_dn,
	output gse_pkg::move_res_t           res
);

	logic signed [1:0]              dr;
	logic signed [1:0]              dc;
	logic signed [gse_pkg::DimW:0]  tr;
	logic signed [gse_pkg::DimW:0]  tc;
	logic                           in_bounds;
	logic [gse_pkg::MaxCols-1:0]    sel_row;

	// Target cell, one bit wider than the grid bound so that -1 stays negative.
	always_comb begin
		dr = gse_pkg::move_dr(move_k);
		dc = gse_pkg::move_dc(move_k);
		tr = $signed({{(gse_pkg::DimW + 1 - gse_pkg::RowW){1'b0}}, row})
			+ $signed({{(gse_pkg::DimW - 1){dr[1]}}, dr});
		tc = $signed({{(gse_pkg::DimW + 1 - gse_pkg::ColW){1'b0}}, col})
			+ $signed({{(gse_pkg::DimW - 1){dc[1]}}, dc});
		in_bounds = !tr[gse_pkg::DimW] && !tc[gse_pkg::DimW]
			&& (tr[gse_pkg::DimW-1:0] < rows_used)
			&& (tc[gse_pkg::DimW-1:0] < cols_used);
	end

	// Pick the stored row that holds the target cell.
	always_comb begin
		case (dr)
			-2'sd1:  sel_row = row_up;
			2'sd1:   sel_row = row_dn;
			default: sel_row = row_mid;
		endcase
	end

	assign res.valid = in_bounds && !sel_row[tc[gse_pkg::ColW-1:0]];
	assign res.row   = tr[gse_pkg::RowW-1:0];
	assign res.col   = tc[gse_pkg::ColW-1:0];

endmodule

FILE: rtl/core/grid_successor_expander.sv
// Top level of the grid successor expander: sequencer, obstacle bitmap and result register.
// Depends on gse_pkg, gse_ram and gse_move_unit.
// Cell write: the bitmap row is read, then written back. Rectangle fill: each rectangle row is read, then written back.
// Query: the three neighbour rows are read, then the eight moves go in turn through the shared move unit;
// the results then go out one per cycle while taken.
// Reset clears the per-row valid bits, so the whole bitmap reads as free at once.
module grid_successor_expander (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  gse_pkg::req_t              in_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output gse_pkg::rsp_t              out_rsp,
	input  logic                       cfg_wen,
	input  logic                       cfg_idx,
	input  logic [gse_pkg::DimW-1:0]   cfg_data
);

	gse_pkg::state_t                state_q;
	logic [gse_pkg::DimW-1:0]       grid_rows_q;
	logic [gse_pkg::DimW-1:0]       grid_cols_q;
	logic [gse_pkg::DimW-1:0]       rows_used;
	logic [gse_pkg::DimW-1:0]       cols_used;
	logic [gse_pkg::MaxRows-1:0]    row_valid_q;
	logic                           rd_valid_q;

	logic [gse_pkg::RowW-1:0]       cur_row_q;
	logic [gse_pkg::DimW-1:0]       end_row_q;
	logic [gse_pkg::MaxCols-1:0]    fill_mask_q;
	logic                           fill_val_q;
	logic [gse_pkg::RowW-1:0]       q_row_q;
	logic [gse_pkg::ColW-1:0]       q_col_q;
	logic [1:0]                     cnt_q;
	logic [2:0]                     move_k_q;
	logic [7:0]                     hit_mask_q;
	logic [gse_pkg::MaxCols-1:0]    nbr_rows_q [3];

	logic                           in_acc;
	logic [gse_pkg::DimW-1:0]       re_clip;
	logic [gse_pkg::DimW-1:0]       ce_clip;
	logic [gse_pkg::MaxCols-1:0]    rect_mask;
	logic [gse_pkg::MaxCols-1:0]    old_row;
	logic [gse_pkg::MaxCols-1:0]    new_row;
	logic [gse_pkg::DimW-1:0]       next_row_ext;

	logic                           ram_we;
	logic                           ram_re;
	logic [gse_pkg::RowW-1:0]       ram_raddr;
	logic [gse_pkg::MaxCols-1:0]    ram_rdata;

	gse_pkg::move_res_t             move_res;
	logic [2:0]                     unit_k;
	logic                           out_valid_q;
	gse_pkg::rsp_t                  out_q;
	logic                           load;
	logic [2:0]                     pick_idx;
	logic [7:0]                     pick_rem;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= gse_pkg::DimW'(gse_pkg::MaxRows);
			grid_cols_q <= gse_pkg::DimW'(gse_pkg::MaxCols);
		end else if (cfg_wen) begin
			case (cfg_idx)
				gse_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data;
				gse_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Grid in use: the stored size, clipped to the maximum grid.
	assign rows_used = (grid_rows_q > gse_pkg::DimW'(gse_pkg::MaxRows))
		? gse_pkg::DimW'(gse_pkg::MaxRows) : grid_rows_q;
	assign cols_used = (grid_cols_q > gse_pkg::DimW'(gse_pkg::MaxCols))
		? gse_pkg::DimW'(gse_pkg::MaxCols) : grid_cols_q;

	assign in_ready = (state_q == gse_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Rectangle bounds clipped to the grid, and the column mask of the rectangle.
	always_comb begin
		re_clip = (in_req.row_end > rows_used) ? rows_used : in_req.row_end;
		ce_clip = (in_req.col_end > cols_used) ? cols_used : in_req.col_end;
		if (ce_clip >= gse_pkg::DimW'(gse_pkg::MaxCols)) begin
			rect_mask = {gse_pkg::MaxCols{1'b1}};
		end else begin
			rect_mask = ~({gse_pkg::MaxCols{1'b1}} << ce_clip[gse_pkg::ColW-1:0]);
		end
		rect_mask = rect_mask & ({gse_pkg::MaxCols{1'b1}} << in_req.col);
	end

	// Bitmap row read back; a row never written reads as free.
	assign old_row      = rd_valid_q ? ram_rdata : '0;
	assign new_row      = (old_row & ~fill_mask_q) | (fill_val_q ? fill_mask_q : '0);
	assign next_row_ext = {1'b0, cur_row_q} + gse_pkg::DimW'(1);

	// Memory port control.
	assign ram_we = (state_q == gse_pkg::ST_FWRITE);
	assign ram_re = (state_q == gse_pkg::ST_FREAD)
		|| ((state_q == gse_pkg::ST_QREAD) && (cnt_q != 2'd3));
	assign ram_raddr = (state_q == gse_pkg::ST_FREAD) ? cur_row_q
		: q_row_q + gse_pkg::RowW'(cnt_q) - gse_pkg::RowW'(1);

	gse_ram #(
		.DATA_W (gse_pkg::MaxCols),
		.DEPTH  (gse_pkg::MaxRows)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (cur_row_q),
		.wr_data (new_row),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Per-row valid bits, cleared at reset and set by the first write of a row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (ram_re) begin
				rd_valid_q <= row_valid_q[ram_raddr];
			end
			if (ram_we) begin
				row_valid_q[cur_row_q] <= 1'b1;
			end
		end
	end

	// Shared move unit, stepped through the eight moves and then reused for the
	// coordinates of each result that goes out.
	assign unit_k = (state_q == gse_pkg::ST_EMIT) ? pick_idx : move_k_q;

	gse_move_unit u_move (
		.move_k    (unit_k),
		.row       (q_row_q),
		.col       (q_col_q),
		.rows_used (rows_used),
		.cols_used (cols_used),
		.row_up    (nbr_rows_q[0]),
		.row_mid   (nbr_rows_q[1]),
		.row_dn    (nbr_rows_q[2]),
		.res       (move_res)
	);

	// Lowest pending successor and the moves left after it.
	always_comb begin
		pick_idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (hit_mask_q[i]) begin
				pick_idx = 3'(i);
			end
		end
		pick_rem = hit_mask_q & ~(8'd1 << pick_idx);
	end

	assign load = (state_q == gse_pkg::ST_EMIT) && (!out_valid_q || out_ready);

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gse_pkg::ST_IDLE;
			cnt_q    <= 2'd0;
			move_k_q <= 3'd0;
		end else begin
			case (state_q)
				gse_pkg::ST_IDLE: begin
					if (in_acc) begin
						case (in_req.mode)
							gse_pkg::MODE_WRITE: begin
								if ((gse_pkg::DimW'(in_req.row) < rows_used)
									&& (gse_pkg::DimW'(in_req.col) < cols_used)) begin
									state_q <= gse_pkg::ST_FREAD;
								end
							end
							gse_pkg::MODE_FILL: begin
								if ((gse_pkg::DimW'(in_req.row) < re_clip)
									&& (gse_pkg::DimW'(in_req.col) < ce_clip)) begin
									state_q <= gse_pkg::ST_FREAD;
								end
							end
							gse_pkg::MODE_QUERY: begin
								state_q <= gse_pkg::ST_QREAD;
								cnt_q   <= 2'd0;
							end
							default: ;
						endcase
					end
				end
				gse_pkg::ST_FREAD: begin
					state_q <= gse_pkg::ST_FWRITE;
				end
				gse_pkg::ST_FWRITE: begin
					state_q <= (next_row_ext >= end_row_q)
						? gse_pkg::ST_IDLE : gse_pkg::ST_FREAD;
				end
				gse_pkg::ST_QREAD: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q  <= gse_pkg::ST_EVAL;
						move_k_q <= 3'd0;
					end
				end
				gse_pkg::ST_EVAL: begin
					move_k_q <= move_k_q + 3'd1;
					if (move_k_q == 3'd7) begin
						state_q <= gse_pkg::ST_EMIT;
					end
				end
				gse_pkg::ST_EMIT: begin
					if (load && (pick_rem == 8'd0)) begin
						state_q <= gse_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gse_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Request payload and working registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			q_row_q   <= in_req.row;
			q_col_q   <= in_req.col;
			cur_row_q <= in_req.row;
			if (in_req.mode == gse_pkg::MODE_FILL) begin
				end_row_q   <= re_clip;
				fill_mask_q <= rect_mask;
				fill_val_q  <= 1'b1;
			end else begin
				end_row_q   <= {1'b0, in_req.row} + gse_pkg::DimW'(1);
				fill_mask_q <= gse_pkg::MaxCols'(1) << in_req.col;
				fill_val_q  <= in_req.cell_value;
			end
		end else if (state_q == gse_pkg::ST_FWRITE) begin
			cur_row_q <= next_row_ext[gse_pkg::RowW-1:0];
		end
		if ((state_q == gse_pkg::ST_QREAD) && (cnt_q != 2'd0)) begin
			case (cnt_q)
				2'd1:    nbr_rows_q[0] <= old_row;
				2'd2:    nbr_rows_q[1] <= old_row;
				default: nbr_rows_q[2] <= old_row;
			endcase
		end
		if (state_q == gse_pkg::ST_EVAL) begin
			hit_mask_q[move_k_q] <= move_res.valid;
		end else if (load) begin
			hit_mask_q <= pick_rem;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; an empty mask means the query found nothing.
	always_ff @(posedge clk) begin
		if (load) begin
			if (hit_mask_q == 8'd0) begin
				out_q <= '{next_row: '0, next_col: '0, move_index: 3'd0,
					found: 1'b0, last: 1'b1};
			end else begin
				out_q.next_row   <= move_res.row;
				out_q.next_col   <= move_res.col;
				out_q.move_index <= pick_idx;
				out_q.found      <= 1'b1;
				out_q.last       <= (pick_rem == 8'd0);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

	// A result without a successor always closes its query.
	a_notfound_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.found |-> out_q.last)
		else $error("not-found result without last");

	// A query request starts the row reads.
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_req.mode == gse_pkg::MODE_QUERY) |=> state_q == gse_pkg::ST_QREAD)
		else $error("query request did not start row reads");

	// The fill walk never writes at or past its end row.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, cur_row_q} < end_row_q))
		else $error("bitmap write beyond the rectangle");

	// Emitting the final successor returns the sequencer to idle.
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		load && (pick_rem == 8'd0) |=> state_q == gse_pkg::ST_IDLE)
		else $error("sequencer stayed busy after the last result");

endmodule

FILE: test/grid_successor_expander_tb.sv
// Self-checking testbench for the grid successor expander: writes, rectangle fills and
// successor queries over several grid sizes. Depends on gse_pkg and the block's RTL.
// A model of the obstacle grid in this module predicts the results of checked and random steps.
module grid_successor_expander_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SettleCycles = 200;
	localparam int HoldCycles   = 300;
	localparam int PhaseItems   = 38;
	localparam int RandomPhases = 4;

	// Receiver pacing styles.
	localparam int PACE_OPEN   = 0;
	localparam int PACE_RANDOM = 1;
	localparam int PACE_TOGGLE = 2;

	// The single result of a query whose neighbors are all out of bounds or blocked.
	localparam gse_pkg::rsp_t NoHit = '{next_row: '0, next_col: '0, move_index: '0,
		found: 1'b0, last: 1'b1};

	// One row of the directed plan: a grid size change or a request.
	typedef struct packed {
		logic                     is_cfg;
		logic                     use_model;
		logic [1:0]               n_fixed;
		gse_pkg::rsp_t [0:2]      fixed;
		gse_pkg::req_t            req;
		logic [gse_pkg::DimW-1:0] rows;
		logic [gse_pkg::DimW-1:0] cols;
	} step_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	gse_pkg::req_t            in_req = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	gse_pkg::rsp_t            out_rsp;
	logic                     cfg_wen = 1'b0;
	logic                     cfg_idx = gse_pkg::REG_GRID_ROWS;
	logic [gse_pkg::DimW-1:0] cfg_data = '0;

	// Model of the obstacle grid and the successors still owed by the block.
	logic [gse_pkg::MaxCols-1:0] blocked [gse_pkg::MaxRows];
	logic [gse_pkg::DimW-1:0]    grid_rows;
	logic [gse_pkg::DimW-1:0]    grid_cols;
	gse_pkg::rsp_t               succ_q [$];
	step_t                       plan [$];
	int                          errors = 0;
	bit                          hold_asked = 1'b0;

	grid_successor_expander dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Rows or columns actually in use for a register value.
	function automatic int span(input logic [gse_pkg::DimW-1:0] reg_val, input int max_val);
		return (int'(reg_val) > max_val) ? max_val : int'(reg_val);
	endfunction

	// Append one result to the list of results owed by the block.
	function automatic void owe(input gse_pkg::rsp_t x);
		succ_q.insert(succ_q.size(), x);
	endfunction

	// Append one row to the directed plan.
	function automatic void add_step(input step_t s);
		plan.insert(plan.size(), s);
	endfunction

	// Update the grid model with one accepted request and, if asked, queue its successors.
	function automatic void apply_request(input gse_pkg::req_t r, input bit predict);
		int            nr, nc, re, ce, tr, tc, dr, dc, n;
		gse_pkg::rsp_t hits [8];
		nr = span(grid_rows, gse_pkg::MaxRows);
		nc = span(grid_cols, gse_pkg::MaxCols);
		n = 0;
		case (r.mode)
			gse_pkg::MODE_WRITE: begin
				if (int'(r.row) < nr && int'(r.col) < nc)
					blocked[r.row][r.col] = r.cell_value;
			end
			gse_pkg::MODE_FILL: begin
				re = (int'(r.row_end) > nr) ? nr : int'(r.row_end);
				ce = (int'(r.col_end) > nc) ? nc : int'(r.col_end);
				for (int i = int'(r.row); i < re; i++)
					for (int j = int'(r.col); j < ce; j++)
						blocked[i][j] = 1'b1;
			end
			gse_pkg::MODE_QUERY: begin
				for (int k = 0; k < 8; k++) begin
					case (k)
						0:       begin dr = 0;  dc = 1;  end
						1:       begin dr = 1;  dc = 1;  end
						2:       begin dr = 1;  dc = 0;  end
						3:       begin dr = 1;  dc = -1; end
						4:       begin dr = 0;  dc = -1; end
						5:       begin dr = -1; dc = -1; end
						6:       begin dr = -1; dc = 0;  end
						default: begin dr = -1; dc = 1;  end
					endcase
					tr = int'(r.row) + dr;
					tc = int'(r.col) + dc;
					if (tr >= 0 && tc >= 0 && tr < nr && tc < nc && !blocked[tr][tc]) begin
						hits[n] = '{next_row: gse_pkg::RowW'(tr),
							next_col: gse_pkg::ColW'(tc),
							move_index: 3'(k), found: 1'b1, last: 1'b0};
						n++;
					end
				end
				if (n == 0) begin
					hits[0] = NoHit;
					n = 1;
				end else begin
					hits[n - 1].last = 1'b1;
				end
				if (predict)
					for (int k = 0; k < n; k++)
						owe(hits[k]);
			end
			default: ;
		endcase
	endfunction

	function automatic gse_pkg::rsp_t hit(input int row, col, k, input bit fin);
		return '{next_row: gse_pkg::RowW'(row), next_col: gse_pkg::ColW'(col),
			move_index: 3'(k), found: 1'b1, last: fin};
	endfunction

	function automatic gse_pkg::req_t cmd(input logic [1:0] mode,
		input int row, col, v, re, ce);
		gse_pkg::req_t r;
		r.mode       = mode;
		r.row        = gse_pkg::RowW'(row);
		r.col        = gse_pkg::ColW'(col);
		r.cell_value = 1'(v);
		r.row_end    = gse_pkg::DimW'(re);
		r.col_end    = gse_pkg::DimW'(ce);
		return r;
	endfunction

	function automatic step_t checked(input gse_pkg::req_t r);
		step_t s;
		s = '0;
		s.use_model = 1'b1;
		s.req = r;
		return s;
	endfunction

	function automatic step_t typed(input gse_pkg::req_t r, input int n,
		input gse_pkg::rsp_t [0:2] f);
		step_t s;
		s = '0;
		s.req = r;
		s.n_fixed = 2'(n);
		s.fixed = f;
		return s;
	endfunction

	function automatic step_t regs(input int rows, cols);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.rows = gse_pkg::DimW'(rows);
		s.cols = gse_pkg::DimW'(cols);
		return s;
	endfunction

	// Grid sizes lean small so that edges and obstacles matter; zero and clipped sizes appear.
	function automatic int pick_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			return $urandom_range(1, 8);
		if (roll < 80)
			return $urandom_range(1, 64);
		if (roll < 90)
			return 64;
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
	endfunction

	// Coordinates mostly inside the grid, often on or just past its far edge.
	function automatic logic [gse_pkg::RowW-1:0] pick_coord(input int lim);
		int roll;
		roll = $urandom_range(0, 99);
		if (lim == 0 || roll < 15)
			return gse_pkg::RowW'($urandom_range(0, 63));
		if (roll < 35)
			return gse_pkg::RowW'(lim - 1 + int'($urandom_range(0, 1)));
		return gse_pkg::RowW'($urandom_range(0, lim - 1));
	endfunction

	function automatic gse_pkg::req_t random_req();
		gse_pkg::req_t r;
		int            roll;
		r.mode       = gse_pkg::MODE_QUERY;
		r.row        = pick_coord(span(grid_rows, gse_pkg::MaxRows));
		r.col        = pick_coord(span(grid_cols, gse_pkg::MaxCols));
		r.cell_value = 1'($urandom_range(0, 1));
		r.row_end    = gse_pkg::DimW'($urandom_range(0, 127));
		r.col_end    = gse_pkg::DimW'($urandom_range(0, 127));
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			r.mode = gse_pkg::MODE_QUERY;
		end else if (roll < 75) begin
			r.mode = gse_pkg::MODE_WRITE;
			r.cell_value = ($urandom_range(0, 9) < 4);
		end else if (roll < 94) begin
			r.mode = gse_pkg::MODE_FILL;
			// Mostly small rectangles, so the grid does not fill up at once.
			if ($urandom_range(0, 9) != 0) begin
				r.row_end = gse_pkg::DimW'(int'(r.row) + int'($urandom_range(0, 3)));
				r.col_end = gse_pkg::DimW'(int'(r.col) + int'($urandom_range(0, 3)));
			end
		end else begin
			r.mode = gse_pkg::MODE_NONE;
			r.row  = gse_pkg::RowW'($urandom_range(0, 63));
			r.col  = gse_pkg::ColW'($urandom_range(0, 63));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Present one request and hold it until the block takes it.
	task automatic offer(input gse_pkg::req_t r);
		in_valid <= 1'b1;
		in_req   <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	// Let every owed result come out, then give a trailing fill time to finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (succ_q.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_grid(input int rows, cols);
		cfg_wen  <= 1'b1;
		cfg_idx  <= gse_pkg::REG_GRID_ROWS;
		cfg_data <= gse_pkg::DimW'(rows);
		@(posedge clk);
		cfg_idx  <= gse_pkg::REG_GRID_COLS;
		cfg_data <= gse_pkg::DimW'(cols);
		@(posedge clk);
		cfg_wen  <= 1'b0;
		grid_rows = gse_pkg::DimW'(rows);
		grid_cols = gse_pkg::DimW'(cols);
	endtask

	// Directed plan, then random phases on random grid sizes.
	initial begin : stimulus
		gse_pkg::req_t r;
		int            counted, gap, burst;
		foreach (blocked[i])
			blocked[i] = '0;
		grid_rows = gse_pkg::DimW'(64);
		grid_cols = gse_pkg::DimW'(64);

		// Corners of the empty full-size grid after reset.
		add_step(typed(cmd(gse_pkg::MODE_QUERY, 0, 0, 0, 0, 0), 3,
			{hit(0, 1, 0, 0), hit(1, 1, 1, 0), hit(1, 0, 2, 1)}));
		add_step(typed(cmd(gse_pkg::MODE_QUERY, 63, 63, 0, 0, 0), 3,
			{hit(63, 62, 4, 0), hit(62, 62, 5, 0), hit(62, 63, 6, 1)}));
		// Block the corner's neighbors, first one and then the other two together, until nothing is left.
		add_step(typed(cmd(gse_pkg::MODE_WRITE, 0, 1, 1, 0, 0), 0, '0));
		add_step(checked(cmd(gse_pkg::MODE_QUERY, 0, 0, 0, 0, 0)));
		add_step(typed(cmd(gse_pkg::MODE_FILL, 1, 0, 0, 2, 2), 0, '0));
		add_step(typed(cmd(gse_pkg::MODE_QUERY, 0, 0, 0, 0, 0), 1,
			{NoHit, NoHit, NoHit}));
		add_step(typed(cmd(gse_pkg::MODE_WRITE, 0, 1, 0, 0, 0), 0, '0));
		// An empty rectangle, then one whose bounds run past the grid.
		add_step(typed(cmd(gse_pkg::MODE_FILL, 5, 5, 1, 5, 9), 0, '0));
		add_step(typed(cmd(gse_pkg::MODE_FILL, 62, 62, 0, 127, 127), 0, '0));
		add_step(typed(cmd(gse_pkg::MODE_QUERY, 63, 63, 1, 127, 127), 1,
			{NoHit, NoHit, NoHit}));
		add_step(checked(cmd(gse_pkg::MODE_QUERY, 61, 61, 0, 0, 0)));
		// The unused mode with every field at its top value.
		add_step(typed(cmd(gse_pkg::MODE_NONE, 63, 63, 1, 127, 127), 0, '0));
		add_step(checked(cmd(gse_pkg::MODE_QUERY, 30, 30, 0, 0, 0)));
		add_step(typed(cmd(gse_pkg::MODE_WRITE, 63, 0, 1, 0, 0), 0, '0));
		add_step(checked(cmd(gse_pkg::MODE_QUERY, 62, 1, 0, 0, 0)));
		// Smallest grid: a write outside is dropped, a query cell outside still has a neighbor.
		add_step(regs(1, 1));
		add_step(typed(cmd(gse_pkg::MODE_QUERY, 0, 0, 0, 0, 0), 1,
			{NoHit, NoHit, NoHit}));
		add_step(typed(cmd(gse_pkg::MODE_WRITE, 5, 5, 1, 0, 0), 0, '0));
		add_step(checked(cmd(gse_pkg::MODE_QUERY, 1, 1, 0, 0, 0)));
		// No rows at all.
		add_step(regs(0, 64));
		add_step(typed(cmd(gse_pkg::MODE_QUERY, 0, 0, 0, 0, 0), 1,
			{NoHit, NoHit, NoHit}));
		add_step(typed(cmd(gse_pkg::MODE_FILL, 0, 0, 1, 127, 127), 0, '0));
		// Oversized registers clip to the full grid.
		add_step(regs(127, 127));
		add_step(checked(cmd(gse_pkg::MODE_QUERY, 0, 0, 0, 0, 0)));
		add_step(checked(cmd(gse_pkg::MODE_QUERY, 5, 4, 0, 0, 0)));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				set_grid(int'(plan[i].rows), int'(plan[i].cols));
			end else begin
				offer(plan[i].req);
				apply_request(plan[i].req, plan[i].use_model);
				if (!plan[i].use_model)
					for (int k = 0; k < int'(plan[i].n_fixed); k++)
						owe(plan[i].fixed[k]);
			end
		end

		// Random requests in bursts with idle gaps between them.
		burst = 0;
		for (int p = 0; p < RandomPhases; p++) begin
			settle();
			set_grid(pick_size(), pick_size());
			counted = 0;
			while (counted < PhaseItems) begin
				if (burst == 0) begin
					gap = $urandom_range(0, 10);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst = $urandom_range(1, 24);
				end
				// Early in the second phase the receiver backs off for a long stretch.
				if (p == 1 && counted == 5)
					hold_asked = 1'b1;
				r = random_req();
				offer(r);
				apply_request(r, 1'b1);
				burst--;
				if (r.mode != gse_pkg::MODE_NONE)
					counted++;
			end
		end

		settle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Receiver pacing: stretches of open, random and toggling ready, plus one long hold.
	always begin : receiver
		static int pace_left = 0;
		static int pace_style = PACE_OPEN;
		static bit hold_done = 1'b0;
		@(posedge clk);
		if (hold_asked && !hold_done) begin
			hold_done = 1'b1;
			out_ready <= 1'b0;
			repeat (HoldCycles) @(posedge clk);
		end
		if (pace_left == 0) begin
			pace_style = $urandom_range(PACE_OPEN, PACE_TOGGLE);
			pace_left = $urandom_range(4, 60);
		end
		pace_left--;
		case (pace_style)
			PACE_OPEN:   out_ready <= 1'b1;
			PACE_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
			default:     out_ready <= ~out_ready;
		endcase
	end

	// Compare each result taken from the block with the oldest owed successor.
	always @(posedge clk) begin : result_check
		gse_pkg::rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (succ_q.size() == 0) begin
				report_mismatch($sformatf("result with none owed: row %0d col %0d move %0d",
					out_rsp.next_row, out_rsp.next_col, out_rsp.move_index));
			end else begin
				want = succ_q.pop_front();
				if (out_rsp.next_row !== want.next_row)
					report_mismatch($sformatf("next_row %0d, expected %0d",
						out_rsp.next_row, want.next_row));
				if (out_rsp.next_col !== want.next_col)
					report_mismatch($sformatf("next_col %0d, expected %0d",
						out_rsp.next_col, want.next_col));
				if (out_rsp.move_index !== want.move_index)
					report_mismatch($sformatf("move_index %0d, expected %0d",
						out_rsp.move_index, want.move_index));
				if (out_rsp.found !== want.found)
					report_mismatch($sformatf("found %b, expected %b",
						out_rsp.found, want.found));
				if (out_rsp.last !== want.last)
					report_mismatch($sformatf("last %b, expected %b",
						out_rsp.last, want.last));
			end
		end
	end

	initial begin : watchdog
		#(4_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/gse_pkg.sv
rtl/core/gse_ram.sv
rtl/core/gse_move_unit.sv
rtl/core/grid_successor_expander.sv
test/grid_successor_expander_tb.sv
